### hw/rtl/bbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbh_pkg;

  localparam int unsigned NUM_BOUNDS = 7;
  localparam int unsigned LANES      = 8;
  localparam int unsigned BOUND_W    = 32;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned BKT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // One queued request after the bound compares have been done.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [LANES-1:0] le;
    logic [LANES-1:0] wild;
    logic [BKT_W-1:0] idx;
    logic             idx_ok;
  } bbh_item_t;

endpackage

`default_nettype wire

### hw/rtl/bbh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bbh_front #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbh_pkg::BOUND_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bbh_pkg::OP_W-1:0]        in_operation,
  input  logic [bbh_pkg::BOUND_W-1:0]     in_sample_value,
  input  logic [bbh_pkg::BKT_W-1:0]       in_bucket_index,
  output logic                            q_valid,
  input  logic                            q_pop,
  output bbh_pkg::bbh_item_t              q_item
);
  import bbh_pkg::*;

  logic [BOUND_W-1:0] bound_r [NUM_BOUNDS];
  bbh_item_t          item;
  bbh_item_t          slot_r [2];
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic               wp_r;
  logic               rp_r;
  logic               push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < NUM_BOUNDS; i++) begin
        bound_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_BOUNDS))) begin
      bound_r[cfg_index] <= cfg_data;
    end
  end

  // Lanes without a usable bound register, or with a bound of zero, behave as wildcards.
  always_comb begin
    item        = '0;
    item.op     = in_operation;
    item.idx    = in_bucket_index;
    item.idx_ok = ({1'b0, in_bucket_index} < (BKT_W+1)'(DEPTH));
    item.le     = '1;
    item.wild   = '1;
    for (int unsigned b = 0; b < NUM_BOUNDS; b++) begin
      if (b < DEPTH - 1) begin
        item.le[b]   = (in_sample_value <= bound_r[b]);
        item.wild[b] = (bound_r[b] == '0);
      end
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bbh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bbh_back #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  bbh_pkg::bbh_item_t          q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbh_pkg::BKT_W-1:0]   out_bucket,
  output logic [bbh_pkg::CNT_W-1:0]   out_count,
  output logic [bbh_pkg::BKT_W-1:0]   out_busiest_bucket
);
  import bbh_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam logic ST_LOOK = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic             phase_r;
  logic             phase_nxt;
  logic [IDX_W-1:0] busy_r;
  logic [IDX_W-1:0] busy_nxt;
  logic [IDX_W-1:0] prev;
  logic             start_hit;
  logic [BKT_W-1:0] start;
  logic [LANES-1:0] match;
  logic [BKT_W-1:0] sel;
  logic [IDX_W-1:0] adr_a;
  logic             look_fire;
  logic             upd_fire;

  bbh_item_t        it_r;
  logic [BKT_W-1:0] sel_r;
  logic [CNT_W-1:0] rd_a_r;
  logic [CNT_W-1:0] rd_b_r;

  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_adr;
  logic [CNT_W-1:0] inc;
  logic             take;

  logic             out_valid_r;
  logic [BKT_W-1:0] out_bucket_r;
  logic [CNT_W-1:0] out_count_r;
  logic [BKT_W-1:0] out_busy_r;
  logic [BKT_W-1:0] res_bucket;
  logic [CNT_W-1:0] res_count;

  assign look_fire = (phase_r == ST_LOOK) && q_valid;
  assign upd_fire  = (phase_r == ST_UPD) && (!out_valid_r || out_ready);
  assign q_pop     = look_fire;

  // The search starts at the busiest bucket when the sample lies above the
  // bound of the bucket just below it.
  always_comb begin
    prev      = busy_r - IDX_W'(1);
    start_hit = (busy_r != '0) && !q_item.le[BKT_W'(prev)];
    start     = start_hit ? BKT_W'(busy_r) : '0;
    match     = q_item.wild | q_item.le;
    sel       = BKT_W'(LANES - 1);
    for (int b = LANES - 1; b >= 0; b--) begin
      if (match[b] && (BKT_W'(b) >= start)) begin
        sel = BKT_W'(b);
      end
    end
    adr_a = (q_item.op == OP_READ) ? IDX_W'(q_item.idx) : IDX_W'(sel);
  end

  always_ff @(posedge clk) begin
    if (look_fire) begin
      it_r   <= q_item;
      sel_r  <= sel;
      rd_a_r <= vld_r[adr_a] ? cnt_mem[adr_a] : '0;
      rd_b_r <= vld_r[busy_r] ? cnt_mem[busy_r] : '0;
    end
    if (wr_en) begin
      cnt_mem[wr_adr] <= inc;
    end
  end

  always_comb begin
    inc        = rd_a_r + CNT_W'(1);
    take       = !it_r.wild[sel_r] && (inc > rd_b_r);
    wr_en      = 1'b0;
    wr_adr     = IDX_W'(sel_r);
    vld_nxt    = vld_r;
    busy_nxt   = busy_r;
    res_bucket = '0;
    res_count  = '0;
    case (it_r.op)
      OP_ADD: begin
        wr_en      = upd_fire;
        res_bucket = sel_r;
        res_count  = inc;
        if (upd_fire) begin
          vld_nxt[wr_adr] = 1'b1;
        end
        if (take) begin
          busy_nxt = IDX_W'(sel_r);
        end
      end
      OP_READ: begin
        res_bucket = it_r.idx;
        res_count  = it_r.idx_ok ? rd_a_r : '0;
      end
      OP_CLEAR: begin
        busy_nxt = '0;
        if (upd_fire) begin
          vld_nxt = '0;
        end
      end
      default: begin
        res_bucket = '0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      ST_LOOK: begin
        if (look_fire) begin
          phase_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_fire) begin
          phase_nxt = ST_LOOK;
        end
      end
      default: begin
        phase_nxt = ST_LOOK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_LOOK;
      busy_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
      if (upd_fire) begin
        busy_r      <= busy_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_bucket_r <= res_bucket;
      out_count_r  <= res_count;
      out_busy_r   <= BKT_W'(busy_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bucket         = out_bucket_r;
  assign out_count          = out_count_r;
  assign out_busiest_bucket = out_busy_r;

`ifndef NO_ASSERTIONS
  ast_clear: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && (it_r.op == OP_CLEAR) |=> (busy_r == '0) && (vld_r == '0))
    else $error("clear did not reset the counters and the busiest bucket");

  ast_match: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ST_UPD) && (it_r.op == OP_ADD) |->
      (it_r.wild[sel_r] || it_r.le[sel_r]) && ({1'b0, sel_r} < (BKT_W+1)'(DEPTH)))
    else $error("selected bucket does not take the sample");

  ast_busy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && (busy_nxt != busy_r) |-> (it_r.op == OP_CLEAR) || !it_r.wild[sel_r])
    else $error("a wildcard bucket became the busiest bucket");

  ast_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(phase_r == ST_UPD))
    else $error("result loaded outside the update step");
`endif

endmodule

`default_nettype wire

### hw/rtl/bounded_bucket_histogram_top.sv
// Threshold bucket histogram with up to NUM_BUCKETS 64-bit counters.
// Requests arrive on the in_ channel (valid/ready) with an operation: add a
// sample, read one counter, or clear all counters. Every request gives
// exactly one result on the out_ channel (valid/ready): the bucket, its
// count after the operation and the current busiest bucket.
// Bucket bounds are written on the cfg_ channel, which is always ready;
// writes are expected only while no request is in flight.
// A request is bound-compared on entry and held in a two-entry queue. The
// counter unit then handles each request in a look step, which chooses the
// bucket and reads the counter memory, and an update step, which updates
// it and loads the result register. It pops no new request until the
// update step is done, because of the read-modify-write of the counter
// memory together with the busiest-bucket hint. When the receiver stalls,
// the result register holds, the queue keeps taking requests until both
// entries are full, and then in_ready drops.
// Reset clears all counters, the busiest bucket, the bounds and the queue.
`timescale 1ns / 1ps
`default_nettype none

module bounded_bucket_histogram_top #(
  parameter int unsigned NUM_BUCKETS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbh_pkg::BOUND_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bbh_pkg::OP_W-1:0]      in_operation,
  input  logic [bbh_pkg::BOUND_W-1:0]   in_sample_value,
  input  logic [bbh_pkg::BKT_W-1:0]     in_bucket_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bbh_pkg::BKT_W-1:0]     out_bucket,
  output logic [bbh_pkg::CNT_W-1:0]     out_count,
  output logic [bbh_pkg::BKT_W-1:0]     out_busiest_bucket
);
  import bbh_pkg::*;

  // Buckets past the eighth are not implemented, and a search never reaches them.
  localparam int unsigned DEPTH = (NUM_BUCKETS < LANES) ? NUM_BUCKETS : LANES;

  logic      q_valid;
  logic      q_pop;
  bbh_item_t q_item;

  bbh_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_sample_value (in_sample_value),
    .in_bucket_index (in_bucket_index),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item)
  );

  bbh_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_item             (q_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bucket         (out_bucket),
    .out_count          (out_count),
    .out_busiest_bucket (out_busiest_bucket)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bbh_pkg::*;

  localparam int unsigned NBKT = LANES;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BOUND_W-1:0] sample;
    logic [BKT_W-1:0]   idx;
  } hist_req_t;

  typedef struct packed {
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] count;
    logic [BKT_W-1:0] busiest;
  } hist_res_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BOUND_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = OP_NONE;
  logic [BOUND_W-1:0]   in_sample_value = '0;
  logic [BKT_W-1:0]     in_bucket_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BKT_W-1:0]     out_bucket;
  logic [CNT_W-1:0]     out_count;
  logic [BKT_W-1:0]     out_busiest_bucket;

  // Shadow copy of the histogram state.
  logic [BOUND_W-1:0] bound_shadow [NUM_BOUNDS];
  logic [CNT_W-1:0]   tally [NBKT];
  logic [BKT_W-1:0]   leader;

  hist_req_t pending_req [$];
  hist_res_t due_result [$];
  hist_req_t seen_req;
  hist_req_t next_req;

  int send_pct = 0;
  int hold_pct = 0;
  int send_gap = 0;
  int hold_gap = 0;
  int errors = 0;

  bounded_bucket_histogram_top #(
    .NUM_BUCKETS(NBKT)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sample_value   (in_sample_value),
    .in_bucket_index   (in_bucket_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bucket        (out_bucket),
    .out_count         (out_count),
    .out_busiest_bucket(out_busiest_bucket)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [BOUND_W-1:0] limit_of(int b);
    if (b >= NBKT - 1 || b >= NUM_BOUNDS) return '0;
    return bound_shadow[b];
  endfunction

  function automatic hist_res_t histogram_update(hist_req_t r);
    hist_res_t res;
    int b;
    int busy;
    bit done;
    res = '0;
    case (r.op)
      OP_ADD: begin
        busy = leader;
        b = 0;
        done = 1'b0;
        // The search may begin at the busiest bucket.
        if (busy != 0 && r.sample > limit_of(busy - 1)) b = busy;
        while (!done) begin
          if (limit_of(b) == '0) begin
            tally[b] = tally[b] + 1'b1;
            done = 1'b1;
          end else if (r.sample <= limit_of(b)) begin
            tally[b] = tally[b] + 1'b1;
            if (tally[b] > tally[busy]) leader = BKT_W'(b);
            done = 1'b1;
          end else begin
            b++;
          end
        end
        res.bucket = BKT_W'(b);
        res.count  = tally[b];
      end
      OP_READ: begin
        res.bucket = r.idx;
        res.count  = tally[r.idx];
      end
      OP_CLEAR: begin
        for (int i = 0; i < NBKT; i++) tally[i] = '0;
        leader = '0;
      end
      default: begin
      end
    endcase
    res.busiest = leader;
    return res;
  endfunction

  task automatic flag(input string what);
    errors++;
    if (errors <= 100) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_result();
    hist_res_t want;
    if (due_result.size() == 0) begin
      flag($sformatf("result with no request pending, bucket %0d", out_bucket));
    end else begin
      want = due_result.pop_front();
      if (out_bucket !== want.bucket)
        flag($sformatf("bucket %0d, predicted %0d", out_bucket, want.bucket));
      if (out_count !== want.count)
        flag($sformatf("count %0d, predicted %0d", out_count, want.count));
      if (out_busiest_bucket !== want.busiest)
        flag($sformatf("busiest %0d, predicted %0d", out_busiest_bucket, want.busiest));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen_req = '{in_operation, in_sample_value, in_bucket_index};
        due_result.push_back(histogram_update(seen_req));
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap == 0 && send_pct != 0 && $urandom_range(99) < send_pct)
          send_gap = $urandom_range(9, 1);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          next_req = pending_req.pop_front();
          in_valid        <= 1'b1;
          in_operation    <= next_req.op;
          in_sample_value <= next_req.sample;
          in_bucket_index <= next_req.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result();
      if (hold_gap == 0 && hold_pct != 0 && $urandom_range(99) < hold_pct)
        hold_gap = $urandom_range(9, 1);
      if (hold_gap != 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stim
    logic [BOUND_W-1:0] vals [$];
    int fav;

    for (int i = 0; i < NUM_BOUNDS; i++) bound_shadow[i] = '0;
    for (int i = 0; i < NBKT; i++) tally[i] = '0;
    leader = '0;
    fav = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // All buckets are wildcards right after reset.
    send_pct = 30;
    hold_pct = 30;
    push_req(OP_ADD, 32'd0, 3'd0);
    push_req(OP_ADD, 32'hFFFF_FFFF, 3'd7);
    push_req(OP_READ, $urandom, 3'd0);
    push_req(OP_READ, $urandom, 3'd7);
    push_req(OP_NONE, $urandom, 3'd5);
    push_req(OP_CLEAR, $urandom, 3'd2);
    settle();

    // Ascending bounds, then build up bucket 3 so the search hint kicks in.
    for (int i = 0; i < NUM_BOUNDS; i++) set_bound(i, BOUND_W'((i + 1) * 10));
    set_bound(NUM_BOUNDS, 32'hA5A5_5A5A);
    push_req(OP_ADD, 32'd0, 3'd0);
    push_req(OP_ADD, 32'd10, 3'd0);
    push_req(OP_ADD, 32'd11, 3'd0);
    push_req(OP_ADD, 32'd70, 3'd0);
    push_req(OP_ADD, 32'd71, 3'd0);
    push_req(OP_ADD, 32'hFFFF_FFFF, 3'd0);
    repeat (3) push_req(OP_ADD, 32'd35, 3'd0);
    push_req(OP_ADD, 32'd5, 3'd0);
    push_req(OP_ADD, 32'd35, 3'd0);
    push_req(OP_READ, 32'd0, 3'd3);
    push_req(OP_NONE, 32'hFFFF_FFFF, 3'd7);
    push_req(OP_CLEAR, 32'd0, 3'd0);
    settle();

    // Extreme bounds with wildcards in the middle.
    set_bound(0, 32'd1);
    set_bound(1, 32'd0);
    set_bound(2, 32'hFFFF_FFFF);
    set_bound(3, 32'd5);
    set_bound(4, 32'hFFFF_FFFE);
    set_bound(5, 32'd0);
    set_bound(6, 32'd3);
    set_bound(NUM_BOUNDS, 32'd0);
    push_req(OP_ADD, 32'd0, 3'd0);
    push_req(OP_ADD, 32'd1, 3'd0);
    push_req(OP_ADD, 32'd2, 3'd0);
    push_req(OP_ADD, 32'hFFFF_FFFF, 3'd0);
    push_req(OP_READ, 32'd0, 3'd1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      vals.delete();
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (ph == 4) vals.push_back(32'd1);
        else if (ph == 5) vals.push_back(32'hFFFF_FFFF);
        else vals.push_back(pick_bound());
      end
      if (ph % 2 == 0) vals.sort();
      for (int i = 0; i < NUM_BOUNDS; i++) set_bound(i, vals[i]);
      fav = $urandom_range(NUM_BOUNDS - 1);
      send_pct = (ph % 3) * 25;
      hold_pct = ((ph + 1) % 3) * 25;
      random_batch(200, fav);
      settle();
    end

    // Closing stretch runs at full rate on both sides.
    send_pct = 0;
    hold_pct = 0;
    for (int i = 0; i < NUM_BOUNDS; i++) set_bound(i, pick_bound());
    random_batch(100, $urandom_range(NUM_BOUNDS - 1));
    settle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_req(input logic [OP_W-1:0] op, input logic [BOUND_W-1:0] v,
                          input logic [BKT_W-1:0] idx);
    hist_req_t r;
    r = '{op, v, idx};
    pending_req.push_back(r);
  endtask

  // Waits until every request has been sent and answered.
  task automatic settle();
    while (pending_req.size() != 0 || in_valid || due_result.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bound(input int idx, input logic [BOUND_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx < NUM_BOUNDS) bound_shadow[idx] = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BOUND_W-1:0] pick_bound();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return BOUND_W'($urandom_range(1000, 1));
    endcase
  endfunction

  // Samples mostly land on or next to a bound, often the phase's favorite.
  function automatic logic [BOUND_W-1:0] pick_sample(int fav);
    int b;
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      default: begin
        b = $urandom_range(1) ? fav : $urandom_range(NUM_BOUNDS - 1);
        return bound_shadow[b] + BOUND_W'($urandom_range(2)) - 32'd1;
      end
    endcase
  endfunction

  task automatic random_batch(input int n, input int fav);
    int pick;
    logic [OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 78) op = OP_ADD;
      else if (pick < 92) op = OP_READ;
      else if (pick < 96) op = OP_NONE;
      else op = OP_CLEAR;
      push_req(op, (op == OP_ADD) ? pick_sample(fav) : BOUND_W'($urandom),
               BKT_W'($urandom_range(NBKT - 1)));
    end
  endtask

endmodule

### bounded_bucket_histogram_top.f
hw/rtl/bbh_pkg.sv
hw/rtl/bbh_front.sv
hw/rtl/bbh_back.sv
hw/rtl/bounded_bucket_histogram_top.sv
tb/tb_top.sv
